FILE: rtl/tthpd_pkg.sv
// ----------------------------------------------------------------------------
// tthpd_pkg
// shared types and constants of the turn-to-heading pd controller
// ----------------------------------------------------------------------------
package tthpd_pkg;

	// operation codes of an input transaction
	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_TICK   = 2'd1,
		OP_CANCEL = 2'd2
	} op_t;

	// status codes of a result transaction
	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_DRIVE    = 3'd1,
		ST_DONE     = 3'd2,
		ST_TIMEOUT  = 3'd3,
		ST_NOIMU    = 3'd4
	} status_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_GAIN_ERROR       = 3'd0,
		REG_GAIN_RATE        = 3'd1,
		REG_TARGET_TOLERANCE = 3'd2,
		REG_RATE_TOLERANCE   = 3'd3,
		REG_FINE_ZONE        = 3'd4,
		REG_TIMEOUT_LIMIT    = 3'd5
	} reg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [9:0]  gain_error;
		logic [9:0]  gain_rate;
		logic [14:0] target_tolerance;
		logic [15:0] rate_tolerance;
		logic [14:0] fine_zone;
		logic [15:0] timeout_limit;
	} cfg_t;

	localparam logic [9:0]  RST_GAIN_ERROR       = 10'd141;
	localparam logic [9:0]  RST_GAIN_RATE        = 10'd230;
	localparam logic [14:0] RST_TARGET_TOLERANCE = 15'd400;
	localparam logic [15:0] RST_RATE_TOLERANCE   = 16'd800;
	localparam logic [14:0] RST_FINE_ZONE        = 15'd1500;
	localparam logic [15:0] RST_TIMEOUT_LIMIT    = 16'd8000;

	// target wrap: turns = floor((|deg| + 179) / 360) by reciprocal
	localparam logic [15:0] WRAP_BIAS = 16'd179;
	localparam logic [15:0] DEG_RECIP = 16'd46604;
	localparam int          DEG_SHIFT = 24;
	localparam int          TURNS_W   = 7;

	localparam logic [23:0] CDEG_PER_DEG = 24'd100;
	localparam logic [23:0] CDEG_TURN_W  = 24'd36000;
	localparam logic signed [16:0] CDEG_HALF = 17'sd18000;
	localparam logic signed [16:0] CDEG_TURN = 17'sd36000;

	// omega limits
	localparam logic [5:0] OMEGA_MAX      = 6'd45;
	localparam logic [5:0] OMEGA_MIN      = 6'd10;
	localparam logic [5:0] OMEGA_FINE_MAX = 6'd14;
	localparam logic [5:0] OMEGA_FINE_MIN = 6'd6;

	// numerator scale is 25600 per unit of omega
	localparam logic signed [29:0] LIM_COARSE   = 30'sd1152000;
	localparam logic signed [29:0] LIM_FINE     = 30'sd358400;
	localparam logic [20:0]        ROUND_HALF   = 21'd12800;
	localparam logic [12:0]        DIV100_RECIP = 13'd5243;
	localparam int                 DIV100_SHIFT = 19;

	// control step outcome handed to the omega stage
	typedef struct packed {
		logic               acc;
		logic               res;
		status_t            status;
		logic               fine;
		logic signed [16:0] err;
		logic signed [18:0] rate;
	} step_t;

	typedef struct packed {
		status_t           status;
		logic signed [6:0] omega;
		logic              last;
	} result_t;

	localparam int RQ_DEPTH = 4;

endpackage

FILE: rtl/tthpd_cfg.sv
// ----------------------------------------------------------------------------
// tthpd_cfg
// configuration register file written through the config channel
// ----------------------------------------------------------------------------
module tthpd_cfg
	import tthpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_error       <= RST_GAIN_ERROR;
			cfg_q.gain_rate        <= RST_GAIN_RATE;
			cfg_q.target_tolerance <= RST_TARGET_TOLERANCE;
			cfg_q.rate_tolerance   <= RST_RATE_TOLERANCE;
			cfg_q.fine_zone        <= RST_FINE_ZONE;
			cfg_q.timeout_limit    <= RST_TIMEOUT_LIMIT;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_GAIN_ERROR:       cfg_q.gain_error       <= wr_data[9:0];
				REG_GAIN_RATE:        cfg_q.gain_rate        <= wr_data[9:0];
				REG_TARGET_TOLERANCE: cfg_q.target_tolerance <= wr_data[14:0];
				REG_RATE_TOLERANCE:   cfg_q.rate_tolerance   <= wr_data;
				REG_FINE_ZONE:        cfg_q.fine_zone        <= wr_data[14:0];
				REG_TIMEOUT_LIMIT:    cfg_q.timeout_limit    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/tthpd_step.sv
// ----------------------------------------------------------------------------
// tthpd_step
// input register, turn state and control decision of one transaction
// ----------------------------------------------------------------------------
module tthpd_step
	import tthpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [1:0]         in_op,
	input  logic signed [15:0] head_deg,
	input  logic [15:0]        tick_ms,
	input  logic signed [15:0] yaw_now,
	input  logic signed [18:0] yaw_rate,
	input  logic               imu_ready,
	input  cfg_t               cfg,
	output step_t              step_s2
);

	// whole turns to strip from the target, found before the input register
	logic [15:0] tmag;
	logic [15:0] tsum;
	logic [31:0] tprod;

	assign tmag  = head_deg[15] ? 16'(-head_deg) : 16'(head_deg);
	assign tsum  = tmag + WRAP_BIAS;
	assign tprod = 32'(tsum) * 32'(DEG_RECIP);

	logic                vld_s1;
	op_t                 op_s1;
	logic signed [15:0]  tdeg_s1;
	logic [TURNS_W-1:0]  turns_s1;
	logic [15:0]         elapsed_s1;
	logic signed [15:0]  yaw_s1;
	logic signed [18:0]  rate_s1;
	logic                imu_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1      <= op_t'(in_op);
			tdeg_s1    <= head_deg;
			turns_s1   <= tprod[DEG_SHIFT +: TURNS_W];
			elapsed_s1 <= tick_ms;
			yaw_s1     <= yaw_now;
			rate_s1    <= yaw_rate;
			imu_s1     <= imu_ready;
		end
	end

	// turn state
	logic        armed_q, armed_d;
	logic [15:0] goal_q, goal_d;
	logic [15:0] time_q, time_d;

	// goal of a start in centidegrees
	logic [23:0] tdeg_x;
	logic [23:0] turn_cdeg;
	logic [23:0] goal_wide;
	logic        is_start;
	logic [15:0] goal_use;

	assign is_start  = (op_s1 == OP_START);
	assign tdeg_x    = {{8{tdeg_s1[15]}}, tdeg_s1};
	assign turn_cdeg = 24'(turns_s1) * CDEG_TURN_W;
	assign goal_wide = tdeg_x * CDEG_PER_DEG - (tdeg_s1[15] ? -turn_cdeg : turn_cdeg);
	assign goal_use  = is_start ? goal_wide[15:0] : goal_q;

	// heading error, one turn of wrap is enough for these ranges
	logic signed [16:0] diff;
	logic signed [16:0] err;
	logic [14:0]        aerr;
	logic [18:0]        arate;

	assign diff = {goal_use[15], goal_use} - {yaw_s1[15], yaw_s1};

	always_comb begin
		if (diff > CDEG_HALF) begin
			err = diff - CDEG_TURN;
		end else if (diff < -CDEG_HALF) begin
			err = diff + CDEG_TURN;
		end else begin
			err = diff;
		end
	end

	assign aerr  = err[16] ? 15'(-err) : 15'(err);
	assign arate = rate_s1[18] ? 19'(-rate_s1) : 19'(rate_s1);

	// turn time, saturating at the limit
	logic [15:0] t_base;
	logic [15:0] t_add;
	logic [16:0] t_sum;
	logic [15:0] t_new;

	assign t_base = is_start ? '0 : time_q;
	assign t_add  = is_start ? '0 : elapsed_s1;
	assign t_sum  = {1'b0, t_base} + {1'b0, t_add};

	always_comb begin
		if (t_base < cfg.timeout_limit) begin
			t_new = (t_sum > {1'b0, cfg.timeout_limit}) ? cfg.timeout_limit : t_sum[15:0];
		end else begin
			t_new = t_base;
		end
	end

	logic    done;
	logic    timeout;
	logic    ctrl_end;
	status_t ctrl_status;

	assign done     = (aerr <= cfg.target_tolerance) && (arate <= {3'b000, cfg.rate_tolerance});
	assign timeout  = (t_new >= cfg.timeout_limit);
	assign ctrl_end = done || timeout;

	always_comb begin
		if (done) begin
			ctrl_status = ST_DONE;
		end else if (timeout) begin
			ctrl_status = ST_TIMEOUT;
		end else begin
			ctrl_status = ST_DRIVE;
		end
	end

	step_t nxt;

	always_comb begin
		nxt        = '0;
		nxt.status = ST_ACCEPTED;
		nxt.fine   = (aerr <= cfg.fine_zone);
		nxt.err    = err;
		nxt.rate   = rate_s1;
		armed_d    = armed_q;
		goal_d     = goal_q;
		time_d     = time_q;
		if (vld_s1) begin
			case (op_s1)
				OP_START: begin
					nxt.res = 1'b1;
					if (!imu_s1) begin
						nxt.status = ST_NOIMU;
					end else begin
						nxt.acc    = 1'b1;
						nxt.status = ctrl_status;
						goal_d     = goal_wide[15:0];
						armed_d    = !ctrl_end;
						time_d     = ctrl_end ? '0 : t_new;
					end
				end
				OP_TICK: begin
					if (armed_q) begin
						nxt.res = 1'b1;
						if (!imu_s1) begin
							nxt.status = ST_NOIMU;
							armed_d    = 1'b0;
							time_d     = '0;
						end else begin
							nxt.status = ctrl_status;
							armed_d    = !ctrl_end;
							time_d     = ctrl_end ? '0 : t_new;
						end
					end
				end
				OP_CANCEL: begin
					armed_d = 1'b0;
					time_d  = '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			goal_q  <= '0;
			time_q  <= '0;
			step_s2 <= '0;
		end else if (adv) begin
			armed_q <= armed_d;
			goal_q  <= goal_d;
			time_q  <= time_d;
			step_s2 <= nxt;
		end
	end

endmodule

FILE: rtl/tthpd_law.sv
// ----------------------------------------------------------------------------
// tthpd_law
// pd numerator register and omega limit, rounding and minimum
// ----------------------------------------------------------------------------
module tthpd_law
	import tthpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  step_t   step_s2,
	input  cfg_t    cfg,
	output logic    acc_s3,
	output logic    res_s3,
	output result_t ctrl
);

	logic signed [29:0] pe;
	logic signed [29:0] pr;
	logic signed [29:0] num_s3;
	status_t            status_s3;
	logic               fine_s3;

	assign pe = 30'($signed(step_s2.err)) * 30'($signed({1'b0, cfg.gain_error}));
	assign pr = 30'($signed(step_s2.rate)) * 30'($signed({1'b0, cfg.gain_rate}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s3 <= 1'b0;
			res_s3 <= 1'b0;
		end else if (adv) begin
			acc_s3 <= step_s2.acc;
			res_s3 <= step_s2.res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3    <= pe - pr;
			status_s3 <= step_s2.status;
			fine_s3   <= step_s2.fine;
		end
	end

	logic signed [29:0] lim;
	logic [5:0]         mx;
	logic [5:0]         mn;
	logic [28:0]        anum;
	logic [20:0]        rsum;
	logic [25:0]        rprod;
	logic [5:0]         mag;
	logic [5:0]         mag_min;
	logic signed [6:0]  om;

	assign lim  = fine_s3 ? LIM_FINE : LIM_COARSE;
	assign mx   = fine_s3 ? OMEGA_FINE_MAX : OMEGA_MAX;
	assign mn   = fine_s3 ? OMEGA_FINE_MIN : OMEGA_MIN;
	assign anum = num_s3[29] ? 29'(-num_s3) : 29'(num_s3);

	// inside the limits |num| stays below 2^21, so the low bits suffice
	assign rsum    = anum[20:0] + ROUND_HALF;
	assign rprod   = 26'(rsum[20:8]) * 26'(DIV100_RECIP);
	assign mag     = rprod[DIV100_SHIFT +: 6];
	assign mag_min = ((mag != '0) && (mag < mn)) ? mn : mag;

	always_comb begin
		if (num_s3 > lim) begin
			om = $signed({1'b0, mx});
		end else if (num_s3 < -lim) begin
			om = -$signed({1'b0, mx});
		end else if (num_s3[29]) begin
			om = -$signed({1'b0, mag_min});
		end else begin
			om = $signed({1'b0, mag_min});
		end
	end

	assign ctrl.status = status_s3;
	assign ctrl.omega  = (status_s3 == ST_DRIVE) ? om : '0;
	assign ctrl.last   = 1'b1;

endmodule

FILE: rtl/tthpd_rq.sv
// ----------------------------------------------------------------------------
// tthpd_rq
// small result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module tthpd_rq
	import tthpd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr0_en,
	input  result_t                      wr0,
	input  logic                         wr1_en,
	input  result_t                      wr1,
	input  logic                         rd_en,
	output result_t                      rd_data,
	output logic [$clog2(RQ_DEPTH+1)-1:0] cnt
);

	localparam int PTR_W = $clog2(RQ_DEPTH);
	localparam int CNT_W = $clog2(RQ_DEPTH + 1);

	result_t            mem [RQ_DEPTH];
	logic [PTR_W-1:0]   wp_q;
	logic [PTR_W-1:0]   rp_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;

	assign pop = rd_en && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (wr0_en) begin
			mem[wp_q] <= wr0;
		end
		if (wr0_en && wr1_en) begin
			mem[wp_q + PTR_W'(1)] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr0_en) begin
				wp_q <= wp_q + (wr1_en ? PTR_W'(2) : PTR_W'(1));
			end
			if (pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(wr0_en) + CNT_W'(wr0_en && wr1_en) - CNT_W'(pop);
		end
	end

	assign rd_data = mem[rp_q];
	assign cnt     = cnt_q;

endmodule

FILE: rtl/turn_to_heading_pd_controller_core.sv
// ----------------------------------------------------------------------------
// turn_to_heading_pd_controller_core
// closed-loop turn to a yaw target with a pd law on heading error and rate
// ----------------------------------------------------------------------------
// A start transaction wraps the target degrees into [-180,180] and checks the
// imu flag: if set, it returns an accepted result followed at once by one
// control result and arms the loop unless that step ends the turn, else one
// noimu result. A tick runs a control step while armed, a cancel disarms.
// While the result queue has room the block takes one input transaction per
// cycle: the input is registered, the control decision and turn state update
// happen in the next stage, the pd numerator is registered after that and
// omega is formed on the way into a four-entry result queue. The slave side
// stays ready while the queue holds two results or fewer, so a run of ticks
// goes through at one per cycle if the master keeps up, and a start, which
// yields two results, is paced by the master side draining one per cycle.
// ----------------------------------------------------------------------------
module turn_to_heading_pd_controller_core
	import tthpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// head_deg [15:0], tick_ms [31:16], yaw_now [47:32],
	// yaw_rate [66:48], imu_ready [67], zero [71:68]
	input  logic [71:0]           s_axis_tdata,
	// operation [1:0]
	input  logic [1:0]            s_axis_tuser,

	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// omega [6:0], zero [7]
	output logic [7:0]            m_axis_tdata,
	// status [2:0]
	output logic [2:0]            m_axis_tuser,
	output logic                  m_axis_tlast,

	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(RQ_DEPTH + 1);

	cfg_t              cfg;
	step_t             step_s2;
	logic              acc_s3;
	logic              res_s3;
	result_t           ctrl;
	result_t           acc_res;
	result_t           rd_data;
	logic [CNT_W-1:0]  rq_cnt;
	logic              adv;

	// registers are always writable
	assign cfg_ready = 1'b1;

	tthpd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the whole pipeline moves together while the queue has room for two
	assign adv           = (rq_cnt <= CNT_W'(RQ_DEPTH - 2));
	assign s_axis_tready = adv;

	tthpd_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (s_axis_tvalid),
		.in_op      (s_axis_tuser),
		.head_deg   (s_axis_tdata[15:0]),
		.tick_ms    (s_axis_tdata[31:16]),
		.yaw_now    (s_axis_tdata[47:32]),
		.yaw_rate   (s_axis_tdata[66:48]),
		.imu_ready  (s_axis_tdata[67]),
		.cfg        (cfg),
		.step_s2    (step_s2)
	);

	tthpd_law u_law (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.step_s2 (step_s2),
		.cfg     (cfg),
		.acc_s3  (acc_s3),
		.res_s3  (res_s3),
		.ctrl    (ctrl)
	);

	// accepted result of a start goes ahead of its control result
	assign acc_res.status = ST_ACCEPTED;
	assign acc_res.omega  = '0;
	assign acc_res.last   = 1'b0;

	tthpd_rq u_rq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr0_en  (adv && res_s3),
		.wr0     (acc_s3 ? acc_res : ctrl),
		.wr1_en  (adv && res_s3 && acc_s3),
		.wr1     (ctrl),
		.rd_en   (m_axis_tready),
		.rd_data (rd_data),
		.cnt     (rq_cnt)
	);

	assign m_axis_tvalid = (rq_cnt != '0);
	assign m_axis_tdata  = {1'b0, rd_data.omega};
	assign m_axis_tuser  = rd_data.status;
	assign m_axis_tlast  = rd_data.last;

	// queue never overfills
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt <= CNT_W'(RQ_DEPTH))
		else $error("result queue count above depth");

	// an accepted result never travels without its control result
	a_acc_pair: assert property (@(posedge clk) disable iff (!arst_n)
		acc_s3 |-> res_s3)
		else $error("accepted result without control result");

	// the control result is already queued when the accepted one leaves
	a_acc_follow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("control result missing after accepted result");

	// omega only carries a value on a drive result
	a_omega_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_DRIVE) |-> (m_axis_tdata[6:0] == '0))
		else $error("nonzero omega on a non-drive result");

endmodule

FILE: tb/turn_to_heading_pd_controller_core_test.sv
// ----------------------------------------------------------------------------
// turn_to_heading_pd_controller_core_test
// self-checking bench for the turn-to-heading pd controller core
// ----------------------------------------------------------------------------
// Start, tick and cancel commands go in on the input stream, and the results
// on the result stream are checked one by one. A small predictor class keeps
// its own copy of the gains, tolerances and turn state. It works out the
// results of every command the block takes and checks each result against
// the oldest one still waiting. Idle spells hit both streams. A directed set
// covers the heading wrap ends, the imu cases, the ignored commands and the
// omega limits. After that, several register setups each get a run of random
// turns: starts followed by ticks that steer the yaw toward the goal, with
// noise mixed in.
// ----------------------------------------------------------------------------
module turn_to_heading_pd_controller_core_test;
	import tthpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// operation code the block must ignore
	localparam logic [1:0] OP_RESERVED = 2'd3;
	// register indexes past the last register, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam longint OMEGA_SCALE = 25600;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     ITEMS_PER_SETUP = 100;
	localparam int     SETUP_COUNT = 8;

	// one command on the input stream
	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] head_deg;
		logic [15:0]        tick_ms;
		logic signed [15:0] yaw_now;
		logic signed [18:0] yaw_rate;
		logic               imu_ready;
	} heading_cmd_t;

	// receiver stall patterns
	typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

	// ------------------------------------------------------------------------
	// turn predictor: register copy, turn state and the queue of results
	// still owed by the block
	// ------------------------------------------------------------------------
	class turn_predictor;
		longint   gain_err;
		longint   gain_rate;
		longint   tol_err;
		longint   tol_rate;
		longint   fine_zone;
		longint   timeout_ms;
		bit       armed;
		longint   goal_cdeg;
		longint   turn_ms;
		result_t  owed_results[$];
		int       errors;

		function new();
			gain_err   = longint'(RST_GAIN_ERROR);
			gain_rate  = longint'(RST_GAIN_RATE);
			tol_err    = longint'(RST_TARGET_TOLERANCE);
			tol_rate   = longint'(RST_RATE_TOLERANCE);
			fine_zone  = longint'(RST_FINE_ZONE);
			timeout_ms = longint'(RST_TIMEOUT_LIMIT);
			armed      = 1'b0;
			goal_cdeg  = 0;
			turn_ms    = 0;
			errors     = 0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GAIN_ERROR:       gain_err   = longint'(data[9:0]);
				REG_GAIN_RATE:        gain_rate  = longint'(data[9:0]);
				REG_TARGET_TOLERANCE: tol_err    = longint'(data[14:0]);
				REG_RATE_TOLERANCE:   tol_rate   = longint'(data[15:0]);
				REG_FINE_ZONE:        fine_zone  = longint'(data[14:0]);
				REG_TIMEOUT_LIMIT:    timeout_ms = longint'(data[15:0]);
				default: ;
			endcase
		endfunction

		// steps by whole turns until v lies in [-half, half]
		function longint wrap_span(longint v, longint half);
			longint per;
			per = 2 * half;
			if (v > half)
				v -= per * ((v - half + per - 1) / per);
			else if (v < -half)
				v += per * ((-half - v + per - 1) / per);
			return v;
		endfunction

		function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		function void owe(status_t st, longint om, bit last);
			result_t r;
			r.status = st;
			r.omega  = om[6:0];
			r.last   = last;
			owed_results.push_back(r);
		endfunction

		function void disarm();
			armed   = 1'b0;
			turn_ms = 0;
		endfunction

		function void control_step(heading_cmd_t c, longint elapsed);
			longint err, rate, num, lim, m, om, mx, mn;
			if (!c.imu_ready) begin
				disarm();
				owe(ST_NOIMU, 0, 1'b1);
				return;
			end
			if (turn_ms < timeout_ms) begin
				turn_ms = turn_ms + elapsed;
				if (turn_ms > timeout_ms)
					turn_ms = timeout_ms;
			end
			rate = longint'(c.yaw_rate);
			err  = wrap_span(goal_cdeg - longint'(c.yaw_now), 18000);
			if (mag(err) <= tol_err && mag(rate) <= tol_rate) begin
				disarm();
				owe(ST_DONE, 0, 1'b1);
				return;
			end
			if (turn_ms >= timeout_ms) begin
				disarm();
				owe(ST_TIMEOUT, 0, 1'b1);
				return;
			end
			if (mag(err) <= fine_zone) begin
				mx = longint'(OMEGA_FINE_MAX);
				mn = longint'(OMEGA_FINE_MIN);
			end else begin
				mx = longint'(OMEGA_MAX);
				mn = longint'(OMEGA_MIN);
			end
			num = err * gain_err - rate * gain_rate;
			lim = mx * OMEGA_SCALE;
			if (num > lim) begin
				om = mx;
			end else if (num < -lim) begin
				om = -mx;
			end else begin
				// half away from zero, then the minimum turn rate
				m = (mag(num) + OMEGA_SCALE / 2) / OMEGA_SCALE;
				if (m > 0 && m < mn)
					m = mn;
				om = (num < 0) ? -m : m;
			end
			owe(ST_DRIVE, om, 1'b1);
		endfunction

		// an input transaction was taken by the block
		function void take_command(heading_cmd_t c);
			case (c.op)
				OP_START: begin
					if (!c.imu_ready) begin
						owe(ST_NOIMU, 0, 1'b0 + 1'b1);
					end else begin
						goal_cdeg = wrap_span(longint'(c.head_deg), 180) * 100;
						turn_ms   = 0;
						armed     = 1'b1;
						owe(ST_ACCEPTED, 0, 1'b0);
						control_step(c, 0);
					end
				end
				OP_TICK: begin
					if (armed)
						control_step(c, longint'(c.tick_ms));
				end
				OP_CANCEL: disarm();
				default: ;
			endcase
		endfunction

		// a result transaction left the block
		function void check_result(logic [2:0] st, logic [6:0] om, logic last);
			result_t want;
			if (owed_results.size() == 0) begin
				$error("result with nothing expected: status %0d omega %0d last %0b",
					st, $signed(om), last);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				errors++;
			end
			if (om !== want.omega) begin
				$error("omega: expected %0d, actual %0d", $signed(want.omega), $signed(om));
				errors++;
			end
			if (last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and block
	// ------------------------------------------------------------------------
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [71:0]           s_axis_tdata = '0;
	logic [1:0]            s_axis_tuser = OP_TICK;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;
	logic [2:0]            m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_GAIN_ERROR;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	turn_predictor predictor = new();

	int       burst_left = 0;
	rx_mode_t rx_mode = RX_STEADY;
	int       rx_left = 0;
	int       rx_stall = 0;

	always #5 clk = ~clk;

	turn_to_heading_pd_controller_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// ------------------------------------------------------------------------
	// monitor: every handshake is seen at the clock edge that completes it,
	// with the values from just before that edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		heading_cmd_t seen;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				predictor.write_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready) begin
				seen.op        = s_axis_tuser;
				seen.head_deg  = s_axis_tdata[15:0];
				seen.tick_ms   = s_axis_tdata[31:16];
				seen.yaw_now   = s_axis_tdata[47:32];
				seen.yaw_rate  = s_axis_tdata[66:48];
				seen.imu_ready = s_axis_tdata[67];
				predictor.take_command(seen);
			end
			if (m_axis_tvalid && m_axis_tready)
				predictor.check_result(m_axis_tuser, m_axis_tdata[6:0], m_axis_tlast);
		end
	end

	// ------------------------------------------------------------------------
	// receiver: switches between steady, light, heavy and bursty stalls
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(10, 150);
		end
		rx_left--;
		case (rx_mode)
			RX_STEADY: m_axis_tready <= 1'b1;
			RX_LIGHT:  m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:  m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: begin
				if (rx_stall > 0) begin
					rx_stall--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						rx_stall = $urandom_range(1, 12);
				end
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// driver tasks
	// ------------------------------------------------------------------------
	function automatic int span_rand(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic heading_cmd_t cmd(logic [1:0] op, int tgt, int el, int yaw,
			int rate, bit imu);
		heading_cmd_t c;
		c.op        = op;
		c.head_deg  = 16'(tgt);
		c.tick_ms   = 16'(el);
		c.yaw_now   = 16'(yaw);
		c.yaw_rate  = 19'(rate);
		c.imu_ready = imu;
		return c;
	endfunction

	// one input transaction; the sender goes in bursts with gaps between
	task automatic send_cmd(input heading_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c.op;
		s_axis_tdata  <= {4'b0, c.imu_ready, c.yaw_rate, c.yaw_now, c.tick_ms,
			c.head_deg};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// hold the sender until every owed result has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (predictor.pending() != 0) @(posedge clk);
	endtask

	// one register write; valid stays up for a following write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// a full register setup, written only once the block has gone quiet
	task automatic apply_setup(input int ge, input int gr, input int tt, input int rt,
			input int fz, input int tl, input bit spare);
		wait_drained();
		// commands with no result may still sit in the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write(REG_GAIN_ERROR, CFG_DATA_W'(ge));
		cfg_write(REG_GAIN_RATE, CFG_DATA_W'(gr));
		cfg_write(REG_TARGET_TOLERANCE, CFG_DATA_W'(tt));
		cfg_write(REG_RATE_TOLERANCE, CFG_DATA_W'(rt));
		cfg_write(REG_FINE_ZONE, CFG_DATA_W'(fz));
		cfg_write(REG_TIMEOUT_LIMIT, CFG_DATA_W'(tl));
		if (spare) begin
			cfg_write(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 65535)));
			cfg_write(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 65535)));
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random command, mostly turns toward the current goal, with noise
	task automatic make_cmd(output heading_cmd_t c);
		int r, start_pct, w, y;
		r = $urandom_range(0, 99);
		start_pct = predictor.armed ? 8 : 55;
		if (r < start_pct)
			c.op = OP_START;
		else if (r < 90)
			c.op = OP_TICK;
		else if (r < 95)
			c.op = OP_CANCEL;
		else
			c.op = OP_RESERVED;
		c.imu_ready = ($urandom_range(0, 19) != 0);

		r = $urandom_range(0, 9);
		if (r < 7)
			c.head_deg = 16'(span_rand(180));
		else if (r < 9)
			c.head_deg = 16'(span_rand(720));
		else
			c.head_deg = 16'($urandom_range(0, 65535));

		r = $urandom_range(0, 19);
		if (r < 16)
			c.tick_ms = 16'($urandom_range(0, 250));
		else if (r < 19)
			c.tick_ms = 16'($urandom_range(0, 3000));
		else
			c.tick_ms = 16'($urandom_range(0, 65535));

		// yaw near the goal so that turns settle, reach the fine zone or drive hard
		r = $urandom_range(0, 9);
		if (r < 3)
			w = int'(predictor.tol_err) + 100;
		else if (r < 6)
			w = int'(predictor.fine_zone) + 500;
		else
			w = 18000;
		y = int'(predictor.goal_cdeg) + span_rand(w);
		if (y > 18000)
			y -= 36000;
		else if (y < -18000)
			y += 36000;
		if (r == 9)
			c.yaw_now = 16'($urandom_range(0, 65535));
		else
			c.yaw_now = 16'(y);

		r = $urandom_range(0, 9);
		if (r < 3)
			c.yaw_rate = 19'(span_rand(int'(predictor.tol_rate) + 200));
		else if (r < 5)
			c.yaw_rate = 19'(span_rand(1500));
		else if (r < 7)
			c.yaw_rate = 19'(span_rand(20000));
		else if (r < 9)
			c.yaw_rate = 19'(span_rand(200000));
		else
			c.yaw_rate = 19'($urandom_range(0, 524287));
	endtask

	task automatic run_random(input int n);
		heading_cmd_t c;
		int taken;
		bit paused;
		taken = 0;
		paused = 1'b0;
		while (taken < n) begin
			make_cmd(c);
			send_cmd(c);
			taken++;
			// pause mid-run until the result stream is empty
			if (!paused && taken >= n / 2) begin
				paused = 1'b1;
				wait_drained();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed commands with the reset setup
		send_cmd(cmd(OP_START, 90, 0, 0, 0, 1'b0));         // start without imu
		send_cmd(cmd(OP_TICK, 0, 10, 0, 0, 1'b1));          // tick while disarmed
		send_cmd(cmd(OP_RESERVED, 10, 10, 0, 0, 1'b1));     // ignored operation
		send_cmd(cmd(OP_START, 180, 0, 0, 0, 1'b1));        // upper wrap end, coarse drive
		send_cmd(cmd(OP_TICK, 0, 10, 18000, 0, 1'b1));      // arrived
		send_cmd(cmd(OP_START, -180, 0, 17999, 0, 1'b1));   // lower wrap end
		send_cmd(cmd(OP_START, 540, 0, -18000, 900, 1'b1)); // steps down a full turn
		send_cmd(cmd(OP_START, -540, 0, 0, -900, 1'b1));    // steps up a full turn
		send_cmd(cmd(OP_START, 32767, 0, -32768, 262143, 1'b1));
		send_cmd(cmd(OP_RESERVED, 0, 0, 0, 0, 1'b1));       // ignored while armed
		send_cmd(cmd(OP_START, -32768, 65535, 32767, -262144, 1'b1));
		send_cmd(cmd(OP_TICK, 0, 65535, 0, 0, 1'b1));       // time saturates, timeout
		send_cmd(cmd(OP_START, 90, 0, 0, 0, 1'b1));
		send_cmd(cmd(OP_TICK, 0, 20, 0, 0, 1'b0));          // imu drops mid-turn
		send_cmd(cmd(OP_START, 10, 0, 0, 0, 1'b1));         // fine zone, lands on the fine minimum
		send_cmd(cmd(OP_TICK, 0, 20, 500, 900, 1'b1));      // negative, fine minimum
		send_cmd(cmd(OP_TICK, 0, 20, 500, 306, 1'b1));      // rounds to zero omega
		send_cmd(cmd(OP_CANCEL, 0, 0, 0, 0, 1'b1));
		send_cmd(cmd(OP_TICK, 0, 20, 0, 0, 1'b1));          // nothing after cancel
		send_cmd(cmd(OP_START, -45, 0, 0, -30000, 1'b1));   // coarse drive against rate
		send_cmd(cmd(OP_START, 30, 0, 0, 0, 1'b0));         // refused, turn stays armed
		send_cmd(cmd(OP_TICK, 0, 100, 2000, 0, 1'b1));
		send_cmd(cmd(OP_TICK, 0, 100, 3000, 0, 1'b1));      // not arrived, still driving
		send_cmd(cmd(OP_CANCEL, 0, 0, 0, 0, 1'b1));

		// register setups: extremes, zero timeout, unmasked data, spare indexes
		for (int s = 0; s < SETUP_COUNT; s++) begin
			case (s)
				0: apply_setup(1023, 1023, 0, 0, 0, 65535, 1'b0);
				1: apply_setup(0, 0, 18000, 65535, 18000, 1, 1'b0);
				2: apply_setup($urandom_range(64, 512), $urandom_range(64, 512),
					$urandom_range(0, 800), $urandom_range(0, 2000),
					$urandom_range(0, 3000), 0, 1'b0);
				3: apply_setup($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0);
				4: apply_setup(int'(RST_GAIN_ERROR), int'(RST_GAIN_RATE),
					int'(RST_TARGET_TOLERANCE), int'(RST_RATE_TOLERANCE),
					int'(RST_FINE_ZONE), int'(RST_TIMEOUT_LIMIT), 1'b1);
				default: apply_setup($urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 18000), $urandom_range(0, 65535),
					$urandom_range(0, 18000), $urandom_range(1, 65535), 1'b0);
			endcase
			run_random(ITEMS_PER_SETUP);
		end

		// let everything drain, then a few quiet cycles for stray results
		wait_drained();
		repeat (12) @(posedge clk);
		if (predictor.errors == 0 && predictor.pending() == 0)
			$display("turn_to_heading_pd_controller_core_test: done, clean");
		else
			$display("turn_to_heading_pd_controller_core_test: done, errors");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#5ms;
		$display("turn_to_heading_pd_controller_core_test: done, errors");
		$finish;
	end

endmodule
